>>> design/c6502_pkg.sv
// Shared types, opcodes and constants for the 6502 subset execution core.
package c6502_pkg;

  localparam int unsigned MemDepthDefault = 65536;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_STEP  = 2'd1;
  localparam logic [1:0] OP_RESET = 2'd2;

  localparam logic [15:0] RESET_VECTOR = 16'hFFFC;
  localparam logic [15:0] STACK_PAGE   = 16'h0100;

  localparam logic [7:0] OPC_ORA_IMM = 8'h09;
  localparam logic [7:0] OPC_BPL     = 8'h10;
  localparam logic [7:0] OPC_JSR     = 8'h20;
  localparam logic [7:0] OPC_AND_IMM = 8'h29;
  localparam logic [7:0] OPC_BIT_ABS = 8'h2C;
  localparam logic [7:0] OPC_JMP_ABS = 8'h4C;
  localparam logic [7:0] OPC_RTS     = 8'h60;
  localparam logic [7:0] OPC_SEI     = 8'h78;
  localparam logic [7:0] OPC_STY_ZP  = 8'h84;
  localparam logic [7:0] OPC_STA_ZP  = 8'h85;
  localparam logic [7:0] OPC_STX_ZP  = 8'h86;
  localparam logic [7:0] OPC_DEY     = 8'h88;
  localparam logic [7:0] OPC_TXA     = 8'h8A;
  localparam logic [7:0] OPC_STA_ABS = 8'h8D;
  localparam logic [7:0] OPC_STA_IZY = 8'h91;
  localparam logic [7:0] OPC_STA_ABY = 8'h99;
  localparam logic [7:0] OPC_TXS     = 8'h9A;
  localparam logic [7:0] OPC_LDY_IMM = 8'hA0;
  localparam logic [7:0] OPC_LDX_IMM = 8'hA2;
  localparam logic [7:0] OPC_LDA_IMM = 8'hA9;
  localparam logic [7:0] OPC_LDA_ABS = 8'hAD;
  localparam logic [7:0] OPC_BCS     = 8'hB0;
  localparam logic [7:0] OPC_LDA_ABX = 8'hBD;
  localparam logic [7:0] OPC_CPY_IMM = 8'hC0;
  localparam logic [7:0] OPC_INY     = 8'hC8;
  localparam logic [7:0] OPC_CMP_IMM = 8'hC9;
  localparam logic [7:0] OPC_DEX     = 8'hCA;
  localparam logic [7:0] OPC_BNE     = 8'hD0;
  localparam logic [7:0] OPC_CLD     = 8'hD8;
  localparam logic [7:0] OPC_CPX_IMM = 8'hE0;
  localparam logic [7:0] OPC_INC_ABS = 8'hEE;

  // Sources of the byte written to memory by the datapath.
  localparam logic [1:0] PUSH_RET_HI = 2'd0;
  localparam logic [1:0] PUSH_RET_LO = 2'd1;
  localparam logic [1:0] PUSH_REG    = 2'd2;

  // Memory address sources chosen by the controller.
  typedef enum logic [2:0] {
    MA_PC,        // program counter
    MA_PC1,       // pc + 1
    MA_PC2,       // pc + 2
    MA_VEC_LO,    // reset vector low
    MA_VEC_HI,    // reset vector high
    MA_ADDR_IN,   // input item address
    MA_EA,        // effective address register
    MA_STACK      // 0x0100 + sp
  } maddr_e;

  // Controller to datapath commands.
  typedef struct packed {
    maddr_e     mem_sel;
    logic       mem_we;
    logic       mem_wdata_in;   // write input data rather than datapath byte
    logic       ld_opcode;
    logic       ld_lo;          // capture read byte into operand low
    logic       ld_hi;          // capture read byte into operand high
    logic       ea_from_op;     // ea <= {hi,lo}
    logic       ea_zp;          // ea <= {0, lo}
    logic       ea_inc_zp;      // ea <= {0, lo+1} for indirect pointer
    logic       ea_add_y;       // ea <= {hi,lo} + y
    logic       ea_add_x;       // ea <= {hi,lo} + x
    logic       sp_dec;
    logic       sp_inc;
    logic [1:0] push_sel;       // PUSH_RET_HI, PUSH_RET_LO or PUSH_REG
    logic       exec;           // commit register/flag/pc update
    logic       pc_from_vec;    // pc <= {hi,lo}
    logic       set_result;     // load output buffer
    logic [2:0] cycles;
    logic       unimpl;
  } c6502_cmd_t;

endpackage

>>> design/cpu6502_subset_execute.sv
// Top level of the 6502 subset execution core.
// Each input beat writes a memory byte, reloads the PC from the reset vector,
// or executes one instruction, and yields one result beat with the registers.
// Items are handled one at a time through the single port of the internal
// byte memory. A write goes straight to the result; a PC reload reads both
// vector bytes, then comes the update and the result; a step fetches the
// opcode and both operand bytes, then serves any data, pointer and stack
// accesses, then come the state update and the result. The input stays
// stalled while a result beat waits to be taken. No clearing pass runs after
// reset: memory is undefined until written.
module cpu6502_subset_execute #(
  parameter int unsigned MemDepth = c6502_pkg::MemDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // operation[1:0], address[17:2], data[25:18]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata    // pc, a, x, y, sp, flags, cycle_count, unimplemented
);
  import c6502_pkg::*;

  c6502_cmd_t cmd;
  logic [7:0] opcode, status;

  c6502_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .in_op_i(s_axis_tdata[1:0]),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .opcode_i(opcode), .status_i(status), .cmd_o(cmd)
  );

  c6502_datapath #(.MemDepth(MemDepth)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd),
    .in_addr_i(s_axis_tdata[17:2]), .in_data_i(s_axis_tdata[25:18]),
    .opcode_o(opcode), .status_o(status), .result_o(m_axis_tdata)
  );
endmodule

>>> design/c6502_datapath.sv
// Datapath: registers, flags, byte memory and result buffer.
module c6502_datapath #(
  parameter int unsigned MemDepth = c6502_pkg::MemDepthDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  c6502_pkg::c6502_cmd_t  cmd_i,
  input  logic [15:0]            in_addr_i,
  input  logic [7:0]             in_data_i,
  output logic [7:0]             opcode_o,
  output logic [7:0]             status_o,
  output logic [63:0]            result_o
);
  import c6502_pkg::*;

  localparam int unsigned AW = $clog2(MemDepth);

  logic [7:0]  mem [MemDepth];
  logic [7:0]  rdata_q;
  logic [15:0] pc_q, ea_q;
  logic [7:0]  a_q, x_q, y_q, sp_q, p_q, op_q, lo_q, hi_q;
  logic [63:0] res_q;
  logic [15:0] maddr;
  logic [7:0]  wbyte, rbyte;
  logic [15:0] ret, opw;
  logic [7:0]  cmpr, diff, y_dec, y_inc, x_dec, inc_v;
  logic        taken;
  logic [15:0] boff;

  assign ret   = pc_q + 16'd2;
  assign opw   = {hi_q, lo_q};
  assign rbyte = rdata_q;

  // Address selection for the single memory port.
  always_comb begin
    case (cmd_i.mem_sel)
      MA_PC:      maddr = pc_q;
      MA_PC1:     maddr = pc_q + 16'd1;
      MA_PC2:     maddr = pc_q + 16'd2;
      MA_VEC_LO:  maddr = RESET_VECTOR;
      MA_VEC_HI:  maddr = RESET_VECTOR + 16'd1;
      MA_ADDR_IN: maddr = in_addr_i;
      MA_EA:      maddr = ea_q;
      MA_STACK:   maddr = STACK_PAGE | {8'h00, sp_q};
      default:    maddr = pc_q;
    endcase
  end

  // Byte written to memory.
  always_comb begin
    if (cmd_i.mem_wdata_in) begin
      wbyte = in_data_i;
    end else begin
      case (cmd_i.push_sel)
        PUSH_RET_HI: wbyte = ret[15:8];
        PUSH_RET_LO: wbyte = ret[7:0];
        default: begin
          case (op_q)
            OPC_STY_ZP:  wbyte = y_q;
            OPC_STX_ZP:  wbyte = x_q;
            OPC_INC_ABS: wbyte = inc_v;
            default:     wbyte = a_q;
          endcase
        end
      endcase
    end
  end

  // Single-port byte memory with registered read.
  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_we) begin
      mem[maddr[AW-1:0]] <= wbyte;
    end
    rdata_q <= mem[maddr[AW-1:0]];
  end

  // Compare, branch and increment helpers.
  always_comb begin
    case (op_q)
      OPC_CPY_IMM: cmpr = y_q;
      OPC_CPX_IMM: cmpr = x_q;
      default:     cmpr = a_q;
    endcase
    diff = cmpr - lo_q;
    case (op_q)
      OPC_BPL: taken = ~p_q[7];
      OPC_BCS: taken = p_q[0];
      OPC_BNE: taken = ~p_q[1];
      default: taken = 1'b0;
    endcase
    boff  = {{8{lo_q[7]}}, lo_q};
    y_dec = y_q - 8'd1;
    y_inc = y_q + 8'd1;
    x_dec = x_q - 8'd1;
    inc_v = lo_q + 8'd1;
  end

  // Instruction execution and state update.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= '0; a_q <= '0; x_q <= '0; y_q <= '0;
      sp_q <= 8'hFF; p_q <= '0;
    end else begin
      if (cmd_i.sp_dec) sp_q <= sp_q - 8'd1;
      if (cmd_i.sp_inc) sp_q <= sp_q + 8'd1;
      if (cmd_i.pc_from_vec) pc_q <= opw;
      if (cmd_i.exec) begin
        case (op_q)
          OPC_ORA_IMM: begin
            a_q <= a_q | lo_q; p_q[1] <= (a_q | lo_q) == 8'h00; p_q[7] <= a_q[7] | lo_q[7];
            pc_q <= ret;
          end
          OPC_AND_IMM: begin
            a_q <= a_q & lo_q; p_q[1] <= (a_q & lo_q) == 8'h00; p_q[7] <= a_q[7] & lo_q[7];
            pc_q <= ret;
          end
          OPC_BPL, OPC_BCS, OPC_BNE: pc_q <= taken ? ret + boff : ret;
          OPC_JSR, OPC_JMP_ABS: pc_q <= opw;
          OPC_BIT_ABS: begin
            p_q[6] <= rbyte[6]; p_q[7] <= rbyte[7]; p_q[1] <= (a_q & rbyte) == 8'h00;
            pc_q <= pc_q + 16'd3;
          end
          OPC_RTS: pc_q <= opw + 16'd1;
          OPC_SEI: begin p_q[2] <= 1'b1; pc_q <= pc_q + 16'd1; end
          OPC_CLD: begin p_q[3] <= 1'b0; pc_q <= pc_q + 16'd1; end
          OPC_STY_ZP, OPC_STA_ZP, OPC_STX_ZP, OPC_STA_IZY: pc_q <= ret;
          OPC_STA_ABS, OPC_STA_ABY: pc_q <= pc_q + 16'd3;
          OPC_DEY: begin
            y_q <= y_dec; p_q[1] <= y_dec == 8'h00; p_q[7] <= y_dec[7];
            pc_q <= pc_q + 16'd1;
          end
          OPC_INY: begin
            y_q <= y_inc; p_q[1] <= y_inc == 8'h00; p_q[7] <= y_inc[7];
            pc_q <= pc_q + 16'd1;
          end
          OPC_DEX: begin
            x_q <= x_dec; p_q[1] <= x_dec == 8'h00; p_q[7] <= x_dec[7];
            pc_q <= pc_q + 16'd1;
          end
          OPC_TXA: begin
            a_q <= x_q; p_q[1] <= x_q == 8'h00; p_q[7] <= x_q[7]; pc_q <= pc_q + 16'd1;
          end
          OPC_TXS: begin sp_q <= x_q; pc_q <= pc_q + 16'd1; end
          OPC_LDY_IMM: begin
            y_q <= lo_q; p_q[1] <= lo_q == 8'h00; p_q[7] <= lo_q[7]; pc_q <= ret;
          end
          OPC_LDX_IMM: begin
            x_q <= lo_q; p_q[1] <= lo_q == 8'h00; p_q[7] <= lo_q[7]; pc_q <= ret;
          end
          OPC_LDA_IMM: begin
            a_q <= lo_q; p_q[1] <= lo_q == 8'h00; p_q[7] <= lo_q[7]; pc_q <= ret;
          end
          OPC_LDA_ABS, OPC_LDA_ABX: begin
            a_q <= rbyte; p_q[1] <= rbyte == 8'h00; p_q[7] <= rbyte[7];
            pc_q <= pc_q + 16'd3;
          end
          OPC_CPY_IMM, OPC_CMP_IMM, OPC_CPX_IMM: begin
            p_q[1] <= cmpr == lo_q; p_q[0] <= cmpr >= lo_q; p_q[7] <= diff[7];
            pc_q <= ret;
          end
          OPC_INC_ABS: begin
            p_q[1] <= inc_v == 8'h00; p_q[7] <= inc_v[7];
            pc_q <= pc_q + 16'd3;
          end
          default: ;
        endcase
      end
    end
  end

  // Operand, opcode and effective address capture.
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_opcode) op_q <= rbyte;
    if (cmd_i.ld_lo) lo_q <= rbyte;
    if (cmd_i.ld_hi) hi_q <= rbyte;
    if (cmd_i.ea_from_op) ea_q <= opw;
    if (cmd_i.ea_zp) ea_q <= {8'h00, lo_q};
    if (cmd_i.ea_inc_zp) ea_q <= {8'h00, inc_v};
    if (cmd_i.ea_add_y) ea_q <= opw + {8'h00, y_q};
    if (cmd_i.ea_add_x) ea_q <= opw + {8'h00, x_q};
  end

  // Result buffer, filled after the state update has settled.
  always_ff @(posedge clk_i) begin
    if (cmd_i.set_result) begin
      res_q <= {4'd0, cmd_i.unimpl, cmd_i.cycles, p_q, sp_q, y_q, x_q, a_q, pc_q};
    end
  end

  assign opcode_o = op_q;
  assign status_o = p_q;
  assign result_o = res_q;
endmodule

>>> design/c6502_ctrl.sv
// Controller state machine sequencing memory accesses for each item.
module c6502_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            in_op_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  logic [7:0]            opcode_i,
  input  logic [7:0]            status_i,
  output c6502_pkg::c6502_cmd_t cmd_o
);
  import c6502_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_FETCH = 8'b0000_0010,
    S_DEC   = 8'b0000_0100,
    S_OPND  = 8'b0000_1000,
    S_MEM   = 8'b0001_0000,
    S_MEM2  = 8'b0010_0000,
    S_EXEC  = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_e;

  state_e     state_q, state_d;
  logic [2:0] step_q, step_d;
  logic [2:0] cyc_q, cyc_d;
  logic       unimp_q, unimp_d;
  logic       vld_q, vld_d;
  logic       vec_q, vec_d;
  logic       taken;

  assign in_ready_o  = state_q == S_IDLE && (!vld_q || out_ready_i);
  assign out_valid_o = vld_q;

  // Branch condition, used only for the cycle count.
  always_comb begin
    case (opcode_i)
      OPC_BPL: taken = ~status_i[7];
      OPC_BCS: taken = status_i[0];
      OPC_BNE: taken = ~status_i[1];
      default: taken = 1'b0;
    endcase
  end

  // Next state and command generation.
  always_comb begin
    state_d = state_q; step_d = step_q; cyc_d = cyc_q; unimp_d = unimp_q;
    vec_d = vec_q;
    vld_d = vld_q && !out_ready_i;
    cmd_o = '0;
    cmd_o.mem_sel = MA_PC;
    cmd_o.push_sel = PUSH_REG;
    cmd_o.cycles = cyc_q;
    cmd_o.unimpl = unimp_q;
    case (state_q)
      S_IDLE: begin
        if (in_ready_o && in_valid_i) begin
          cyc_d = 3'd0; unimp_d = 1'b0; vec_d = 1'b0;
          case (in_op_i)
            OP_WRITE: begin
              cmd_o.mem_sel = MA_ADDR_IN; cmd_o.mem_we = 1'b1; cmd_o.mem_wdata_in = 1'b1;
              state_d = S_DONE;
            end
            OP_STEP: state_d = S_FETCH;
            OP_RESET: begin
              cmd_o.mem_sel = MA_VEC_LO; vec_d = 1'b1; state_d = S_OPND;
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_FETCH: begin
        // Opcode byte arrives now; ask for the first operand byte.
        cmd_o.ld_opcode = 1'b1;
        cmd_o.mem_sel = MA_PC1;
        state_d = S_DEC;
      end
      S_DEC: begin
        cmd_o.ld_lo = 1'b1;
        cmd_o.mem_sel = MA_PC2;
        state_d = S_OPND;
      end
      S_OPND: begin
        if (vec_q) begin
          cmd_o.ld_lo = 1'b1; cmd_o.mem_sel = MA_VEC_HI;
        end else begin
          cmd_o.ld_hi = 1'b1;
        end
        state_d = S_MEM;
      end
      S_MEM: begin
        step_d = 3'd0;
        if (vec_q) begin
          cmd_o.ld_hi = 1'b1; state_d = S_EXEC;
        end else begin
          // Both operand bytes are in place; set up the effective address.
          case (opcode_i)
            OPC_ORA_IMM, OPC_AND_IMM, OPC_LDY_IMM, OPC_LDX_IMM, OPC_LDA_IMM,
            OPC_CPY_IMM, OPC_CMP_IMM, OPC_CPX_IMM, OPC_SEI, OPC_CLD, OPC_DEY,
            OPC_INY, OPC_DEX, OPC_TXA, OPC_TXS: begin
              cyc_d = 3'd2; state_d = S_EXEC;
            end
            OPC_BPL, OPC_BCS, OPC_BNE: begin
              cyc_d = taken ? 3'd3 : 3'd2; state_d = S_EXEC;
            end
            OPC_JMP_ABS: begin cyc_d = 3'd3; state_d = S_EXEC; end
            OPC_STY_ZP, OPC_STA_ZP, OPC_STX_ZP: begin
              cmd_o.ea_zp = 1'b1; cyc_d = 3'd3; state_d = S_MEM2;
            end
            OPC_STA_ABS, OPC_LDA_ABS, OPC_BIT_ABS: begin
              cmd_o.ea_from_op = 1'b1; cyc_d = 3'd4; state_d = S_MEM2;
            end
            OPC_STA_ABY: begin
              cmd_o.ea_add_y = 1'b1; cyc_d = 3'd5; state_d = S_MEM2;
            end
            OPC_LDA_ABX: begin
              cmd_o.ea_add_x = 1'b1; cyc_d = 3'd4; state_d = S_MEM2;
            end
            OPC_INC_ABS: begin
              cmd_o.ea_from_op = 1'b1; cyc_d = 3'd6; state_d = S_MEM2;
            end
            OPC_STA_IZY: begin
              cmd_o.ea_zp = 1'b1; cyc_d = 3'd6; state_d = S_MEM2;
            end
            OPC_JSR, OPC_RTS: begin cyc_d = 3'd6; state_d = S_MEM2; end
            default: begin
              unimp_d = 1'b1; state_d = S_EXEC;
            end
          endcase
        end
      end
      S_MEM2: begin
        // Data and stack accesses, one memory access per cycle.
        case (opcode_i)
          OPC_STY_ZP, OPC_STA_ZP, OPC_STX_ZP, OPC_STA_ABS, OPC_STA_ABY: begin
            cmd_o.mem_sel = MA_EA; cmd_o.mem_we = 1'b1; state_d = S_EXEC;
          end
          OPC_LDA_ABS, OPC_LDA_ABX, OPC_BIT_ABS: begin
            cmd_o.mem_sel = MA_EA; state_d = S_EXEC;
          end
          OPC_INC_ABS: begin
            case (step_q)
              3'd0: begin cmd_o.mem_sel = MA_EA; step_d = 3'd1; end
              3'd1: begin cmd_o.ld_lo = 1'b1; step_d = 3'd2; end
              default: begin
                cmd_o.mem_sel = MA_EA; cmd_o.mem_we = 1'b1; state_d = S_EXEC;
              end
            endcase
          end
          OPC_STA_IZY: begin
            case (step_q)
              3'd0: begin
                cmd_o.mem_sel = MA_EA; cmd_o.ea_inc_zp = 1'b1; step_d = 3'd1;
              end
              3'd1: begin
                cmd_o.ld_lo = 1'b1; cmd_o.mem_sel = MA_EA; step_d = 3'd2;
              end
              3'd2: begin cmd_o.ld_hi = 1'b1; step_d = 3'd3; end
              3'd3: begin cmd_o.ea_add_y = 1'b1; step_d = 3'd4; end
              default: begin
                cmd_o.mem_sel = MA_EA; cmd_o.mem_we = 1'b1; state_d = S_EXEC;
              end
            endcase
          end
          OPC_JSR: begin
            cmd_o.mem_sel = MA_STACK; cmd_o.mem_we = 1'b1; cmd_o.sp_dec = 1'b1;
            case (step_q)
              3'd0: begin cmd_o.push_sel = PUSH_RET_HI; step_d = 3'd1; end
              default: begin cmd_o.push_sel = PUSH_RET_LO; state_d = S_EXEC; end
            endcase
          end
          OPC_RTS: begin
            case (step_q)
              3'd0: begin cmd_o.sp_inc = 1'b1; step_d = 3'd1; end
              3'd1: begin
                cmd_o.mem_sel = MA_STACK; cmd_o.sp_inc = 1'b1; step_d = 3'd2;
              end
              3'd2: begin
                cmd_o.ld_lo = 1'b1; cmd_o.mem_sel = MA_STACK; step_d = 3'd3;
              end
              default: begin cmd_o.ld_hi = 1'b1; state_d = S_EXEC; end
            endcase
          end
          default: state_d = S_EXEC;
        endcase
      end
      S_EXEC: begin
        cmd_o.exec = !vec_q && !unimp_q;
        cmd_o.pc_from_vec = vec_q;
        state_d = S_DONE;
      end
      S_DONE: begin
        cmd_o.set_result = 1'b1;
        vld_d = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; step_q <= '0; cyc_q <= '0; unimp_q <= 1'b0;
      vld_q <= 1'b0; vec_q <= 1'b0;
    end else begin
      state_q <= state_d; step_q <= step_d; cyc_q <= cyc_d; unimp_q <= unimp_d;
      vld_q <= vld_d; vec_q <= vec_d;
    end
  end

  // A result is only raised from the final state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(vld_q) |-> $past(state_q) == S_DONE) else $error("result without done");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> !in_ready_o) else $error("ready while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DONE |=> state_q == S_IDLE) else $error("done not followed by idle");
endmodule

>>> test/tb_top.sv
// Self-checking testbench for the 6502 subset execution core.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import c6502_pkg::*;

  // Operation code that the core ignores apart from reporting its registers.
  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam int unsigned NumItems = 1900;
  localparam int unsigned HoldCycles = 400;

  // Fields of one result beat.
  typedef struct packed {
    logic        unimpl;
    logic [2:0]  cycles;
    logic [7:0]  flags;
    logic [7:0]  sp;
    logic [7:0]  y;
    logic [7:0]  x;
    logic [7:0]  a;
    logic [15:0] pc;
  } core_state_t;

  // Implemented opcodes, used to draw random instructions.
  localparam logic [7:0] Opcodes [31] = '{
    OPC_ORA_IMM, OPC_BPL, OPC_JSR, OPC_AND_IMM, OPC_BIT_ABS, OPC_JMP_ABS, OPC_RTS,
    OPC_SEI, OPC_STY_ZP, OPC_STA_ZP, OPC_STX_ZP, OPC_DEY, OPC_TXA, OPC_STA_ABS,
    OPC_STA_IZY, OPC_STA_ABY, OPC_TXS, OPC_LDY_IMM, OPC_LDX_IMM, OPC_LDA_IMM,
    OPC_LDA_ABS, OPC_BCS, OPC_LDA_ABX, OPC_CPY_IMM, OPC_INY, OPC_CMP_IMM, OPC_DEX,
    OPC_BNE, OPC_CLD, OPC_CPX_IMM, OPC_INC_ABS
  };

  // Architectural state tracker and expected result store.
  class core_scoreboard;
    bit [7:0]    mem [0:65535];
    bit          written [0:65535];
    bit [15:0]   pc;
    bit [7:0]    a, x, y, sp, p;
    core_state_t result_q[$];
    int          errors;

    function new();
      pc = 16'h0000;
      a = 8'h00;
      x = 8'h00;
      y = 8'h00;
      sp = 8'hFF;
      p = 8'h00;
      errors = 0;
    endfunction

    function void store(bit [15:0] ad, bit [7:0] v);
      mem[ad] = v;
      written[ad] = 1'b1;
    endfunction

    function bit [15:0] word_at(bit [15:0] ad);
      bit [15:0] nx;
      nx = ad + 16'd1;
      return {mem[nx], mem[ad]};
    endfunction

    function void set_zn(bit [7:0] v);
      p[1] = (v == 8'h00);
      p[7] = v[7];
    endfunction

    function bit [2:0] branch(bit take);
      bit [15:0] nx;
      bit [7:0]  off;
      nx = pc + 16'd1;
      off = mem[nx];
      if (take) begin
        pc = pc + 16'd2 + {{8{off[7]}}, off};
        return 3'd3;
      end
      pc = pc + 16'd2;
      return 3'd2;
    endfunction

    function bit [2:0] compare(bit [7:0] r);
      bit [15:0] nx;
      bit [7:0]  v, d;
      nx = pc + 16'd1;
      v = mem[nx];
      d = r - v;
      p[1] = (r == v);
      p[0] = (r >= v);
      p[7] = d[7];
      pc = pc + 16'd2;
      return 3'd2;
    endfunction

    // Executes the instruction at pc; returns 0 for an opcode outside the subset.
    function bit [2:0] execute();
      bit [15:0] p1, ab, ea, ret;
      bit [7:0]  opc, imm, v, zp1;
      opc = mem[pc];
      p1 = pc + 16'd1;
      imm = mem[p1];
      ab = word_at(p1);
      case (opc)
        OPC_ORA_IMM: begin a = a | imm; set_zn(a); pc = pc + 16'd2; return 3'd2; end
        OPC_AND_IMM: begin a = a & imm; set_zn(a); pc = pc + 16'd2; return 3'd2; end
        OPC_BPL: return branch(!p[7]);
        OPC_BCS: return branch(p[0]);
        OPC_BNE: return branch(!p[1]);
        OPC_JSR: begin
          ret = pc + 16'd2;
          store(STACK_PAGE | sp, ret[15:8]);
          sp = sp - 8'd1;
          store(STACK_PAGE | sp, ret[7:0]);
          sp = sp - 8'd1;
          pc = ab;
          return 3'd6;
        end
        OPC_RTS: begin
          sp = sp + 8'd1;
          ret[7:0] = mem[STACK_PAGE | sp];
          sp = sp + 8'd1;
          ret[15:8] = mem[STACK_PAGE | sp];
          pc = ret + 16'd1;
          return 3'd6;
        end
        OPC_BIT_ABS: begin
          v = mem[ab];
          p[6] = v[6];
          p[7] = v[7];
          p[1] = ((a & v) == 8'h00);
          pc = pc + 16'd3;
          return 3'd4;
        end
        OPC_JMP_ABS: begin pc = ab; return 3'd3; end
        OPC_SEI: begin p[2] = 1'b1; pc = pc + 16'd1; return 3'd2; end
        OPC_CLD: begin p[3] = 1'b0; pc = pc + 16'd1; return 3'd2; end
        OPC_STY_ZP: begin store({8'h00, imm}, y); pc = pc + 16'd2; return 3'd3; end
        OPC_STA_ZP: begin store({8'h00, imm}, a); pc = pc + 16'd2; return 3'd3; end
        OPC_STX_ZP: begin store({8'h00, imm}, x); pc = pc + 16'd2; return 3'd3; end
        OPC_DEY: begin y = y - 8'd1; set_zn(y); pc = pc + 16'd1; return 3'd2; end
        OPC_INY: begin y = y + 8'd1; set_zn(y); pc = pc + 16'd1; return 3'd2; end
        OPC_DEX: begin x = x - 8'd1; set_zn(x); pc = pc + 16'd1; return 3'd2; end
        OPC_TXA: begin a = x; set_zn(a); pc = pc + 16'd1; return 3'd2; end
        OPC_TXS: begin sp = x; pc = pc + 16'd1; return 3'd2; end
        OPC_STA_ABS: begin store(ab, a); pc = pc + 16'd3; return 3'd4; end
        OPC_STA_IZY: begin
          zp1 = imm + 8'd1;
          ea = {mem[{8'h00, zp1}], mem[{8'h00, imm}]} + {8'h00, y};
          store(ea, a);
          pc = pc + 16'd2;
          return 3'd6;
        end
        OPC_STA_ABY: begin
          ea = ab + {8'h00, y};
          store(ea, a);
          pc = pc + 16'd3;
          return 3'd5;
        end
        OPC_LDY_IMM: begin y = imm; set_zn(y); pc = pc + 16'd2; return 3'd2; end
        OPC_LDX_IMM: begin x = imm; set_zn(x); pc = pc + 16'd2; return 3'd2; end
        OPC_LDA_IMM: begin a = imm; set_zn(a); pc = pc + 16'd2; return 3'd2; end
        OPC_LDA_ABS: begin a = mem[ab]; set_zn(a); pc = pc + 16'd3; return 3'd4; end
        OPC_LDA_ABX: begin
          ea = ab + {8'h00, x};
          a = mem[ea];
          set_zn(a);
          pc = pc + 16'd3;
          return 3'd4;
        end
        OPC_CPY_IMM: return compare(y);
        OPC_CMP_IMM: return compare(a);
        OPC_CPX_IMM: return compare(x);
        OPC_INC_ABS: begin
          v = mem[ab] + 8'd1;
          store(ab, v);
          set_zn(v);
          pc = pc + 16'd3;
          return 3'd6;
        end
        default: return 3'd0;
      endcase
    endfunction

    // Applies an accepted input beat and queues the result it must produce.
    function void note_item(bit [1:0] kind, bit [15:0] ad, bit [7:0] dv);
      core_state_t r;
      r.cycles = 3'd0;
      r.unimpl = 1'b0;
      case (kind)
        OP_WRITE: store(ad, dv);
        OP_STEP: begin
          r.cycles = execute();
          r.unimpl = (r.cycles == 3'd0);
        end
        OP_RESET: pc = word_at(RESET_VECTOR);
        default: ;
      endcase
      r.pc = pc;
      r.a = a;
      r.x = x;
      r.y = y;
      r.sp = sp;
      r.flags = p;
      result_q.push_back(r);
    endfunction

    task report_mismatch(string field, int got, int want);
      $display("t=%0t mismatch in %s: got %0h, expected %0h", $time, field, got, want);
      errors++;
    endtask

    // Compares one result beat with the oldest expected state.
    task check_beat(logic [63:0] data);
      core_state_t got, want;
      got = data[59:0];
      if (result_q.size() == 0) begin
        report_mismatch("unexpected beat", int'(got.pc), 0);
        return;
      end
      want = result_q.pop_front();
      if (data[63:60] !== 4'h0) report_mismatch("padding", data[63:60], 0);
      if (got.pc !== want.pc) report_mismatch("pc", got.pc, want.pc);
      if (got.a !== want.a) report_mismatch("a", got.a, want.a);
      if (got.x !== want.x) report_mismatch("x", got.x, want.x);
      if (got.y !== want.y) report_mismatch("y", got.y, want.y);
      if (got.sp !== want.sp) report_mismatch("sp", got.sp, want.sp);
      if (got.flags !== want.flags) report_mismatch("flags", got.flags, want.flags);
      if (got.cycles !== want.cycles) report_mismatch("cycles", got.cycles, want.cycles);
      if (got.unimpl !== want.unimpl) report_mismatch("unimpl", got.unimpl, want.unimpl);
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;

  core_scoreboard sb = new();
  int unsigned    items_sent = 0;
  bit             send_idle = 1'b1;
  bit             hold_req = 1'b0;

  always #5 clk_i = ~clk_i;

  cpu6502_subset_execute dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Offers one beat, after a random gap while send_idle is set, and notes it once accepted.
  task send_item(logic [1:0] kind, logic [15:0] ad, logic [7:0] dv);
    int unsigned gap;
    gap = send_idle ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, dv, ad, kind};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_item(kind, ad, dv);
    items_sent++;
  endtask

  // Makes sure a byte the core will read has been written.
  task prime(logic [15:0] ad);
    if (!sb.written[ad]) send_item(OP_WRITE, ad, 8'($urandom_range(0, 255)));
  endtask

  // Places an instruction at the current pc, primes its data and executes it.
  task run_instr(logic [7:0] opc, logic [7:0] b1, logic [7:0] b2);
    logic [15:0] at, ab;
    logic [7:0]  s1, s2, z1;
    at = sb.pc;
    send_item(OP_WRITE, at, opc);
    at = at + 16'd1;
    send_item(OP_WRITE, at, b1);
    at = at + 16'd1;
    send_item(OP_WRITE, at, b2);
    ab = {b2, b1};
    case (opc)
      OPC_BIT_ABS, OPC_LDA_ABS, OPC_INC_ABS: prime(ab);
      OPC_LDA_ABX: prime(ab + {8'h00, sb.x});
      OPC_STA_IZY: begin
        z1 = b1 + 8'd1;
        prime({8'h00, b1});
        prime({8'h00, z1});
      end
      OPC_RTS: begin
        s1 = sb.sp + 8'd1;
        s2 = sb.sp + 8'd2;
        prime(STACK_PAGE | s1);
        prime(STACK_PAGE | s2);
      end
      default: ;
    endcase
    send_item(OP_STEP, 16'($urandom), 8'($urandom));
  endtask

  task reload_pc();
    prime(RESET_VECTOR);
    prime(RESET_VECTOR + 16'd1);
    send_item(OP_RESET, 16'($urandom), 8'($urandom));
  endtask

  // Result side: random stalls, calm stretches and one long hold-off.
  initial begin
    int unsigned n, beats;
    beats = 0;
    m_axis_tready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        n = HoldCycles;
      end else begin
        n = ((beats / 150) % 3 == 2) ? 0 : $urandom_range(0, 15);
      end
      if (n > 0) begin
        m_axis_tready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      sb.check_beat(m_axis_tdata);
      beats++;
    end
  end

  // Stimulus: directed instructions, then random programs.
  initial begin
    logic [7:0]  opc, b1, b2;
    int unsigned r;
    bit          held, drained;
    held = 1'b0;
    drained = 1'b0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset vector, flag extremes and every instruction class.
    send_item(OP_WRITE, RESET_VECTOR, 8'h00);
    send_item(OP_WRITE, RESET_VECTOR + 16'd1, 8'h04);
    send_item(OP_RESET, 16'hFFFF, 8'hFF);
    run_instr(OPC_LDA_IMM, 8'h00, 8'h00);
    run_instr(OPC_LDA_IMM, 8'h80, 8'h00);
    run_instr(OPC_LDX_IMM, 8'hFF, 8'h00);
    run_instr(OPC_LDY_IMM, 8'h00, 8'h00);
    run_instr(OPC_TXA, 8'h00, 8'h00);
    run_instr(OPC_CMP_IMM, 8'hFF, 8'h00);
    run_instr(OPC_CPY_IMM, 8'h01, 8'h00);
    run_instr(OPC_CPX_IMM, 8'h00, 8'h00);
    run_instr(OPC_AND_IMM, 8'h00, 8'h00);
    run_instr(OPC_ORA_IMM, 8'h41, 8'h00);
    run_instr(OPC_DEY, 8'h00, 8'h00);
    run_instr(OPC_INY, 8'h00, 8'h00);
    run_instr(OPC_DEX, 8'h00, 8'h00);
    run_instr(OPC_SEI, 8'h00, 8'h00);
    run_instr(OPC_CLD, 8'h00, 8'h00);
    send_item(OP_WRITE, 16'h0300, 8'hC0);
    run_instr(OPC_BIT_ABS, 8'h00, 8'h03);
    run_instr(OPC_STA_ZP, 8'hFF, 8'h00);
    run_instr(OPC_STX_ZP, 8'h00, 8'h00);
    run_instr(OPC_STY_ZP, 8'h10, 8'h00);
    // Indirect pointer at the top of page zero wraps to byte zero.
    run_instr(OPC_STA_IZY, 8'hFF, 8'h00);
    run_instr(OPC_STA_ABS, 8'hFF, 8'hFF);
    run_instr(OPC_STA_ABY, 8'hF0, 8'hFF);
    run_instr(OPC_LDA_ABX, 8'h10, 8'h03);
    run_instr(OPC_INC_ABS, 8'hFF, 8'hFF);
    run_instr(OPC_BNE, 8'h80, 8'h00);
    run_instr(OPC_BCS, 8'h7F, 8'h00);
    run_instr(OPC_BPL, 8'h02, 8'h00);
    run_instr(OPC_JSR, 8'h00, 8'h20);
    run_instr(OPC_RTS, 8'h00, 8'h00);
    // Stack pointer at zero wraps when pushed.
    run_instr(OPC_LDX_IMM, 8'h00, 8'h00);
    run_instr(OPC_TXS, 8'h00, 8'h00);
    run_instr(OPC_JSR, 8'hF0, 8'hFF);
    run_instr(OPC_JMP_ABS, 8'h00, 8'h05);
    run_instr(8'h24, 8'h00, 8'h00);
    run_instr(8'h6C, 8'h00, 8'h00);
    run_instr(8'hE6, 8'h00, 8'h00);
    send_item(OP_SPARE, 16'hFFFF, 8'hFF);

    // Random programs with random operands, plus stray writes and resets.
    while (items_sent < NumItems) begin
      send_idle = ((items_sent / 200) % 4 != 3);
      if (!held && items_sent > 600) begin
        // Receiver stops for a long stretch while beats keep coming.
        held = 1'b1;
        hold_req = 1'b1;
        send_idle = 1'b0;
        repeat (40) run_instr(OPC_INY, 8'h00, 8'h00);
      end else if (!drained && items_sent > 1200) begin
        // Sender goes quiet until every expected result has come back.
        drained = 1'b1;
        s_axis_tvalid <= 1'b0;
        while (sb.result_q.size() != 0) @(posedge clk_i);
      end
      r = $urandom_range(0, 99);
      if (r < 72) begin
        opc = ($urandom_range(0, 9) == 0) ? 8'($urandom) : Opcodes[$urandom_range(0, 30)];
        b1 = 8'($urandom);
        b2 = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(2, 3)) : 8'($urandom);
        run_instr(opc, b1, b2);
      end else if (r < 84) begin
        send_item(OP_WRITE, 16'($urandom), 8'($urandom));
      end else if (r < 90) begin
        send_item(OP_WRITE, 16'h0200 | 16'($urandom_range(0, 255)), 8'($urandom));
      end else if (r < 95) begin
        if ($urandom_range(0, 1) == 0) begin
          send_item(OP_WRITE, RESET_VECTOR, 8'($urandom));
          send_item(OP_WRITE, RESET_VECTOR + 16'd1, 8'($urandom));
        end
        reload_pc();
      end else begin
        send_item(OP_SPARE, 16'($urandom), 8'($urandom));
      end
    end
    s_axis_tvalid <= 1'b0;

    while (sb.result_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

>>> cpu6502_subset_execute.f
design/c6502_pkg.sv
design/c6502_datapath.sv
design/c6502_ctrl.sv
design/cpu6502_subset_execute.sv
test/tb_top.sv
